[src/lvm_pkg.sv]
// Shared constants for the lookat view-matrix pipeline.
// No dependencies; used by lvm_norm, lvm_unit and lookat_view_matrix.
package lvm_pkg;

  // Magnitude width that a vector is scaled to before its length is taken.
  localparam int SCALE_BITS = 31;
  // The sum of three squared scaled magnitudes fits in this width.
  localparam int SQ_W = 64;
  // One result bit of the integer square root per pipeline stage.
  localparam int SQ_STEPS = SQ_W / 2;

endpackage

[src/lvm_norm.sv]
// Vector scaling stage pair: bit length of the largest magnitude, then a shift
// that leaves exactly lvm_pkg::SCALE_BITS bits. Depends on lvm_pkg.
module lvm_norm #(
  parameter int MW  = 33,
  parameter int SBW = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          vin,
  input  logic [2:0]                    neg_in,
  input  logic [MW-1:0]                 mag_in [3],
  input  logic [SBW-1:0]                sb_in,
  output logic                          vout,
  output logic                          zero,
  output logic [2:0]                    neg_out,
  output logic [lvm_pkg::SCALE_BITS-1:0] sc_out [3],
  output logic [SBW-1:0]                sb_out
);

  localparam int SB  = lvm_pkg::SCALE_BITS;
  localparam int BLW = $clog2(MW + 1);
  localparam int XW  = MW + SB;

  logic [MW-1:0]  any_bits;
  logic [BLW-1:0] bl_next;
  logic           v1;
  logic [BLW-1:0] bl;
  logic [2:0]     neg1;
  logic [MW-1:0]  mag1 [3];
  logic [SBW-1:0] sb1;
  logic [XW-1:0]  wide [3];

  // The bit length of the largest magnitude equals that of the OR of all three.
  always_comb begin
    any_bits = mag_in[0] | mag_in[1] | mag_in[2];
    bl_next  = '0;
    for (int i = 0; i < MW; i++) begin
      if (any_bits[i]) begin
        bl_next = BLW'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= vin;
    end
    if (en) begin
      bl   <= bl_next;
      neg1 <= neg_in;
      mag1 <= mag_in;
      sb1  <= sb_in;
    end
  end

  // Shifting up by SB and down by the bit length covers both directions.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wide[i] = ({{SB{1'b0}}, mag1[i]} << SB) >> bl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= v1;
    end
    if (en) begin
      zero    <= (bl == '0);
      neg_out <= neg1;
      sb_out  <= sb1;
      for (int i = 0; i < 3; i++) begin
        sc_out[i] <= wide[i][SB-1:0];
      end
    end
  end

endmodule

[src/lvm_unit.sv]
// Unit-vector pipeline: scaling, squares, a bit-per-stage square root and a
// bit-per-stage rounded division in three lanes. Depends on lvm_pkg, lvm_norm.
module lvm_unit #(
  parameter int MW   = 33,
  parameter int SBW  = 1,
  parameter int FRAC = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   vin,
  input  logic [2:0]             neg_in,
  input  logic [MW-1:0]          mag_in [3],
  input  logic [SBW-1:0]         sb_in,
  output logic                   vout,
  output logic                   zero,
  output logic signed [FRAC+1:0] comp [3],
  output logic [SBW-1:0]         sb_out
);

  localparam int SB    = lvm_pkg::SCALE_BITS;
  localparam int SQW   = lvm_pkg::SQ_W;
  localparam int STEPS = lvm_pkg::SQ_STEPS;
  localparam int QW    = FRAC + 1;
  localparam int LW    = SB + 1;
  localparam int DW    = SB + FRAC + 2;
  localparam int PLW   = 3 + 3 * SB + 1 + SBW;
  localparam int DPW   = 3 + 1 + SBW;

  logic           nv;
  logic           nzero;
  logic [2:0]     nneg;
  logic [SB-1:0]  nsc [3];
  logic [SBW-1:0] nsb;

  lvm_norm #(
    .MW  (MW),
    .SBW (SBW)
  ) u_norm (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vin     (vin),
    .neg_in  (neg_in),
    .mag_in  (mag_in),
    .sb_in   (sb_in),
    .vout    (nv),
    .zero    (nzero),
    .neg_out (nneg),
    .sc_out  (nsc),
    .sb_out  (nsb)
  );

  // Squares of the scaled magnitudes.
  logic            qv;
  logic [2*SB-1:0] sq [3];
  logic [PLW-1:0]  qpl;

  always_ff @(posedge clk) begin
    if (rst) begin
      qv <= 1'b0;
    end else if (en) begin
      qv <= nv;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= (2*SB)'(nsc[i]) * (2*SB)'(nsc[i]);
      end
      qpl <= {nneg, nsc[0], nsc[1], nsc[2], nzero, nsb};
    end
  end

  // Square root, one result bit per stage.
  logic           sv  [STEPS+1];
  logic [SQW-1:0] sn  [STEPS+1];
  logic [SQW-1:0] sr  [STEPS+1];
  logic [PLW-1:0] spl [STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (en) begin
      sv[0] <= qv;
    end
    if (en) begin
      sn[0]  <= SQW'(sq[0]) + SQW'(sq[1]) + SQW'(sq[2]);
      sr[0]  <= '0;
      spl[0] <= qpl;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_sqrt
    localparam logic [SQW-1:0] BIT = SQW'(1) << (SQW - 2 - 2 * k);
    logic [SQW:0] trial;
    logic         fits;

    always_comb begin
      trial = {1'b0, sr[k]} + {1'b0, BIT};
      fits  = ({1'b0, sn[k]} >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (en) begin
        sv[k+1] <= sv[k];
      end
      if (en) begin
        sn[k+1]  <= fits ? (sn[k] - trial[SQW-1:0]) : sn[k];
        sr[k+1]  <= fits ? ((sr[k] >> 1) + BIT) : (sr[k] >> 1);
        spl[k+1] <= spl[k];
      end
    end
  end

  // Division setup: dividend is the magnitude at FRAC fraction bits plus half
  // the length, so that the truncating quotient rounds half away from zero.
  logic [LW-1:0]  len;
  logic [SB-1:0]  amag [3];

  always_comb begin
    len = sr[STEPS][LW-1:0];
    for (int i = 0; i < 3; i++) begin
      amag[i] = spl[STEPS][PLW-4-i*SB -: SB];
    end
  end

  logic           dv   [QW+1];
  logic [DW-1:0]  drem [QW+1][3];
  logic [QW-1:0]  dq   [QW+1][3];
  logic [LW-1:0]  dlen [QW+1];
  logic [DPW-1:0] dpl  [QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= sv[STEPS];
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        drem[0][i] <= (DW'(amag[i]) << FRAC) + DW'(len[LW-1:1]);
        dq[0][i]   <= '0;
      end
      dlen[0] <= len;
      dpl[0]  <= {spl[STEPS][PLW-1 -: 3], spl[STEPS][SBW:0]};
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [DW-1:0] divisor;
    logic [2:0]    fits;

    always_comb begin
      divisor = DW'(dlen[j]) << (FRAC - j);
      for (int i = 0; i < 3; i++) begin
        fits[i] = (drem[j][i] >= divisor);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j+1] <= 1'b0;
      end else if (en) begin
        dv[j+1] <= dv[j];
      end
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          drem[j+1][i] <= fits[i] ? (drem[j][i] - divisor) : drem[j][i];
          dq[j+1][i]   <= {dq[j][i][QW-2:0], fits[i]};
        end
        dlen[j+1] <= dlen[j];
        dpl[j+1]  <= dpl[j];
      end
    end
  end

  // Put the signs back.
  logic [2:0] fneg;

  assign fneg = dpl[QW][DPW-1 -: 3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= dv[QW];
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        comp[i] <= fneg[i] ? -$signed({1'b0, dq[QW][i]}) : $signed({1'b0, dq[QW][i]});
      end
      zero   <= dpl[QW][SBW];
      sb_out <= dpl[QW][SBW-1:0];
    end
  end

endmodule

[src/lvm_frame.sv]
// Matrix assembly: recomputed up axis, clamped translation dot products,
// rounding and saturation of all three rows. No package dependency.
module lvm_frame #(
  parameter int W    = 32,
  parameter int FRAC = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   vin,
  input  logic                   degen_in,
  input  logic signed [FRAC+1:0] fwd [3],
  input  logic signed [FRAC+1:0] rgt [3],
  input  logic signed [W-1:0]    eye [3],
  output logic                   vout,
  output logic                   degen_out,
  output logic signed [W-1:0]    rows [3][4]
);

  localparam int UW  = FRAC + 2;
  localparam int MW2 = 2 * UW;
  localparam int EW  = MW2 + 1 - FRAC;
  localparam int PW  = EW + W;
  localparam int AW  = (PW > 63) ? PW : 63;
  localparam int CW  = 63;
  localparam int SW  = CW + 2;
  localparam int NW  = SW + 1;
  localparam int RW  = NW + 1;
  localparam int XW  = ((EW > W) ? EW : W) + 1;

  localparam logic [MW2:0]          HALF_U = (MW2+1)'(1) << (FRAC - 1);
  localparam logic [RW-1:0]         HALF_R = RW'(1) << (FRAC - 1);
  localparam logic signed [AW-1:0]  CMAX   = {{(AW-62){1'b0}}, 1'b1, 61'd0};
  localparam logic signed [RW-1:0]  SMAX   = {{(RW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [RW-1:0]  SMIN   = ~SMAX;
  localparam logic signed [XW-1:0]  XMAX   = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0]  XMIN   = ~XMAX;

  // Stage 1: products of forward x right.
  logic                   v1, dg1;
  logic signed [MW2-1:0]  p1 [6];
  logic signed [UW-1:0]   f1 [3];
  logic signed [UW-1:0]   r1 [3];
  logic signed [W-1:0]    e1 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= vin;
    end
    if (en) begin
      p1[0] <= fwd[1] * rgt[2];
      p1[1] <= fwd[2] * rgt[1];
      p1[2] <= fwd[2] * rgt[0];
      p1[3] <= fwd[0] * rgt[2];
      p1[4] <= fwd[0] * rgt[1];
      p1[5] <= fwd[1] * rgt[0];
      f1    <= fwd;
      r1    <= rgt;
      e1    <= eye;
      dg1   <= degen_in;
    end
  end

  // Stage 2: cross product differences at twice the fraction bits.
  logic                  v2, dg2;
  logic signed [MW2:0]   d2 [3];
  logic signed [UW-1:0]  f2 [3];
  logic signed [UW-1:0]  r2 [3];
  logic signed [W-1:0]   e2 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d2[i] <= (MW2+1)'(p1[2*i]) - (MW2+1)'(p1[2*i+1]);
      end
      f2  <= f1;
      r2  <= r1;
      e2  <= e1;
      dg2 <= dg1;
    end
  end

  // Stage 3: round the up axis back to FRAC fraction bits, half away from
  // zero; a negative value takes a bias one smaller and an arithmetic shift.
  logic signed [MW2:0]  rs3 [3];
  logic                 v3, dg3;
  logic signed [EW-1:0] el3 [3][3];
  logic signed [W-1:0]  e3 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rs3[i] = d2[i] + $signed(d2[i][MW2] ? (HALF_U - 1'b1) : HALF_U);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        el3[0][i] <= EW'(r2[i]);
        el3[1][i] <= EW'(rs3[i] >>> FRAC);
        el3[2][i] <= EW'(f2[i]);
      end
      e3  <= e2;
      dg3 <= dg2;
    end
  end

  // Stage 4: translation products.
  logic                 v4, dg4;
  logic signed [PW-1:0] p4 [3][3];
  logic signed [EW-1:0] el4 [3][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          p4[k][i] <= PW'(el3[k][i]) * PW'(e3[i]);
        end
      end
      el4 <= el3;
      dg4 <= dg3;
    end
  end

  // Stage 5: product magnitudes are clamped to 2^61.
  logic signed [AW-1:0] pe5 [3][3];
  logic                 v5, dg5;
  logic signed [CW-1:0] c5 [3][3];
  logic signed [EW-1:0] el5 [3][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        pe5[k][i] = AW'(p4[k][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          if (pe5[k][i] > CMAX) begin
            c5[k][i] <= CW'(CMAX);
          end else if (pe5[k][i] < -CMAX) begin
            c5[k][i] <= CW'(-CMAX);
          end else begin
            c5[k][i] <= CW'(pe5[k][i]);
          end
        end
      end
      el5 <= el4;
      dg5 <= dg4;
    end
  end

  // Stage 6: dot product sums.
  logic                 v6, dg6;
  logic signed [SW-1:0] a6 [3];
  logic signed [EW-1:0] el6 [3][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        a6[k] <= SW'(c5[k][0]) + SW'(c5[k][1]) + SW'(c5[k][2]);
      end
      el6 <= el5;
      dg6 <= dg5;
    end
  end

  // Stage 7: negate; rounding is symmetric, so this equals negating later.
  logic                 v7, dg7;
  logic signed [NW-1:0] n7 [3];
  logic signed [EW-1:0] el7 [3][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        n7[k] <= -NW'(a6[k]);
      end
      el7 <= el6;
      dg7 <= dg6;
    end
  end

  // Stage 8: round the translation, saturate everything, zero a degenerate
  // frame.
  logic signed [RW-1:0] t8 [3];
  logic signed [XW-1:0] x8 [3][3];
  logic signed [W-1:0]  rows_next [3][4];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      t8[k] = (RW'(n7[k]) + $signed(n7[k][NW-1] ? (HALF_R - 1'b1) : HALF_R)) >>> FRAC;
      if (t8[k] > SMAX) begin
        rows_next[k][3] = W'(SMAX);
      end else if (t8[k] < SMIN) begin
        rows_next[k][3] = W'(SMIN);
      end else begin
        rows_next[k][3] = W'(t8[k]);
      end
      for (int i = 0; i < 3; i++) begin
        x8[k][i] = XW'(el7[k][i]);
        if (x8[k][i] > XMAX) begin
          rows_next[k][i] = W'(XMAX);
        end else if (x8[k][i] < XMIN) begin
          rows_next[k][i] = W'(XMIN);
        end else begin
          rows_next[k][i] = W'(x8[k][i]);
        end
      end
      if (dg7) begin
        for (int i = 0; i < 4; i++) begin
          rows_next[k][i] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= v7;
    end
    if (en) begin
      rows      <= rows_next;
      degen_out <= dg7;
    end
  end

endmodule

[src/lookat_view_matrix.sv]
// Top level of the lookat view-matrix generator: input difference stage,
// axis pipelines, frame assembly and row serializer.
// Depends on lvm_pkg, lvm_norm, lvm_unit and lvm_frame.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+-----------------------------------------
//   request | in_valid / in_stall  | eye_*, target_*, up_* (signed Q16.16)
//   result  | out_valid / out_stall| row_index, col0..col3, last_row,
//           |                      | degenerate (three results per request)
//
// Every request gives three results, right, up and forward, sent back to
// back while the output does not stall; the single result port limits the
// sustained rate to one request per three results. Most of the delay from
// a request to its first row lies in the two square-root and division
// pipelines. Reset (synchronous) clears only the valid bits of the stages
// and the serializer. A stall on the output freezes the whole pipeline
// through one shared enable, so nothing is lost or sent twice; bubbles in
// the last stage are filled even while the output waits.
module lookat_view_matrix #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] eye_x,
  input  logic signed [COORD_WIDTH-1:0] eye_y,
  input  logic signed [COORD_WIDTH-1:0] eye_z,
  input  logic signed [COORD_WIDTH-1:0] target_x,
  input  logic signed [COORD_WIDTH-1:0] target_y,
  input  logic signed [COORD_WIDTH-1:0] target_z,
  input  logic signed [COORD_WIDTH-1:0] up_x,
  input  logic signed [COORD_WIDTH-1:0] up_y,
  input  logic signed [COORD_WIDTH-1:0] up_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    row_index,
  output logic signed [COORD_WIDTH-1:0] col0,
  output logic signed [COORD_WIDTH-1:0] col1,
  output logic signed [COORD_WIDTH-1:0] col2,
  output logic signed [COORD_WIDTH-1:0] col3,
  output logic                          last_row,
  output logic                          degenerate
);

  localparam int W     = COORD_WIDTH;
  localparam int SB    = lvm_pkg::SCALE_BITS;
  localparam int UW    = FRAC_BITS + 2;
  localparam int PXW   = SB + 1 + UW;
  localparam int DXW   = PXW + 1;
  localparam int SBW1  = 3 + 3 * (W + 1) + 3 * W;
  localparam int SBW2  = 3 + 3 * SB + 1 + 3 * W;
  localparam int SBW3  = 3 * UW + 1 + 3 * W;

  // Row codes, in output order.
  localparam logic [1:0] ROW_RIGHT = 2'd0;
  localparam logic [1:0] ROW_UP    = 2'd1;
  localparam logic [1:0] ROW_FWD   = 2'd2;

  // Shared pipeline enable: every stage moves when the serializer can take
  // the last stage's frame, or when that stage holds a bubble.
  logic en;
  logic fr_v;
  logic ser_free;

  logic       ser_v;
  logic [1:0] cnt;

  assign ser_free = !ser_v || ((cnt == ROW_FWD) && !out_stall);
  assign en       = ser_free || !fr_v;
  assign in_stall = !en;

  // Input stage: eye minus target as sign and magnitude, and the up hint
  // likewise. The magnitude of the difference needs one extra bit.
  logic signed [W-1:0] eye_in [3];
  logic signed [W-1:0] tgt_in [3];
  logic signed [W-1:0] up_in  [3];

  assign eye_in = '{eye_x, eye_y, eye_z};
  assign tgt_in = '{target_x, target_y, target_z};
  assign up_in  = '{up_x, up_y, up_z};

  logic                s1_v;
  logic [2:0]          s1_fneg;
  logic [W:0]          s1_fmag [3];
  logic [2:0]          s1_uneg;
  logic [W-1:0]        s1_umag [3];
  logic signed [W-1:0] s1_eye  [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_fneg[i] <= (eye_in[i] < tgt_in[i]);
        if (eye_in[i] < tgt_in[i]) begin
          s1_fmag[i] <= (W+1)'(tgt_in[i]) - (W+1)'(eye_in[i]);
        end else begin
          s1_fmag[i] <= (W+1)'(eye_in[i]) - (W+1)'(tgt_in[i]);
        end
        s1_uneg[i] <= up_in[i][W-1];
        s1_umag[i] <= up_in[i][W-1] ? $unsigned(-up_in[i]) : $unsigned(up_in[i]);
      end
      s1_eye <= eye_in;
    end
  end

  // Up hint scaling; the forward difference rides along in the sideband.
  logic            un_v;
  logic            un_zero;
  logic [2:0]      un_neg;
  logic [SB-1:0]   un_sc [3];
  logic [SBW1-1:0] un_sb;

  lvm_norm #(
    .MW  (W),
    .SBW (SBW1)
  ) u_up_norm (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vin     (s1_v),
    .neg_in  (s1_uneg),
    .mag_in  (s1_umag),
    .sb_in   ({s1_fneg, s1_fmag[0], s1_fmag[1], s1_fmag[2],
               s1_eye[0], s1_eye[1], s1_eye[2]}),
    .vout    (un_v),
    .zero    (un_zero),
    .neg_out (un_neg),
    .sc_out  (un_sc),
    .sb_out  (un_sb)
  );

  logic [W:0] un_fmag [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      un_fmag[i] = un_sb[SBW1-4-i*(W+1) -: W+1];
    end
  end

  // Forward axis: normalize(eye - target).
  logic                    fu_v;
  logic                    fu_zero;
  logic signed [UW-1:0]    fu_comp [3];
  logic [SBW2-1:0]         fu_sb;

  lvm_unit #(
    .MW   (W + 1),
    .SBW  (SBW2),
    .FRAC (FRAC_BITS)
  ) u_fwd (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .vin    (un_v),
    .neg_in (un_sb[SBW1-1 -: 3]),
    .mag_in (un_fmag),
    .sb_in  ({un_neg, un_sc[0], un_sc[1], un_sc[2], un_zero, un_sb[3*W-1:0]}),
    .vout   (fu_v),
    .zero   (fu_zero),
    .comp   (fu_comp),
    .sb_out (fu_sb)
  );

  // Signed scaled up hint.
  logic [2:0]           fu_uneg;
  logic signed [W-1:0]  fu_eye [3];

  assign fu_uneg = fu_sb[SBW2-1 -: 3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fu_eye[i] = $signed(fu_sb[3*W-1-i*W -: W]);
    end
  end

  logic                  x0_v, x0_degen;
  logic signed [SB:0]    x0_up  [3];
  logic signed [UW-1:0]  x0_fwd [3];
  logic signed [W-1:0]   x0_eye [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      x0_v <= 1'b0;
    end else if (en) begin
      x0_v <= fu_v;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (fu_uneg[i]) begin
          x0_up[i] <= -$signed({1'b0, fu_sb[SBW2-4-i*SB -: SB]});
        end else begin
          x0_up[i] <= $signed({1'b0, fu_sb[SBW2-4-i*SB -: SB]});
        end
      end
      x0_fwd   <= fu_comp;
      x0_eye   <= fu_eye;
      x0_degen <= fu_zero || fu_sb[3*W];
    end
  end

  // Right axis, raw: scaled up x forward.
  logic                   x1_v, x1_degen;
  logic signed [PXW-1:0]  x1_p   [6];
  logic signed [UW-1:0]   x1_fwd [3];
  logic signed [W-1:0]    x1_eye [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      x1_v <= 1'b0;
    end else if (en) begin
      x1_v <= x0_v;
    end
    if (en) begin
      x1_p[0]  <= x0_up[1] * x0_fwd[2];
      x1_p[1]  <= x0_up[2] * x0_fwd[1];
      x1_p[2]  <= x0_up[2] * x0_fwd[0];
      x1_p[3]  <= x0_up[0] * x0_fwd[2];
      x1_p[4]  <= x0_up[0] * x0_fwd[1];
      x1_p[5]  <= x0_up[1] * x0_fwd[0];
      x1_fwd   <= x0_fwd;
      x1_eye   <= x0_eye;
      x1_degen <= x0_degen;
    end
  end

  logic                   x2_v, x2_degen;
  logic signed [DXW-1:0]  x2_d   [3];
  logic signed [UW-1:0]   x2_fwd [3];
  logic signed [W-1:0]    x2_eye [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      x2_v <= 1'b0;
    end else if (en) begin
      x2_v <= x1_v;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        x2_d[i] <= DXW'(x1_p[2*i]) - DXW'(x1_p[2*i+1]);
      end
      x2_fwd   <= x1_fwd;
      x2_eye   <= x1_eye;
      x2_degen <= x1_degen;
    end
  end

  logic [2:0]     x2_neg;
  logic [DXW-1:0] x2_mag [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      x2_neg[i] = x2_d[i][DXW-1];
      x2_mag[i] = x2_d[i][DXW-1] ? $unsigned(-x2_d[i]) : $unsigned(x2_d[i]);
    end
  end

  // Right axis, normalized.
  logic                  ru_v;
  logic                  ru_zero;
  logic signed [UW-1:0]  ru_comp [3];
  logic [SBW3-1:0]       ru_sb;

  lvm_unit #(
    .MW   (DXW),
    .SBW  (SBW3),
    .FRAC (FRAC_BITS)
  ) u_rgt (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .vin    (x2_v),
    .neg_in (x2_neg),
    .mag_in (x2_mag),
    .sb_in  ({x2_fwd[0], x2_fwd[1], x2_fwd[2], x2_degen,
              x2_eye[0], x2_eye[1], x2_eye[2]}),
    .vout   (ru_v),
    .zero   (ru_zero),
    .comp   (ru_comp),
    .sb_out (ru_sb)
  );

  logic signed [UW-1:0] ru_fwd [3];
  logic signed [W-1:0]  ru_eye [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ru_fwd[i] = $signed(ru_sb[SBW3-1-i*UW -: UW]);
      ru_eye[i] = $signed(ru_sb[3*W-1-i*W -: W]);
    end
  end

  // Frame assembly.
  logic                fr_degen;
  logic signed [W-1:0] fr_rows [3][4];

  lvm_frame #(
    .W    (W),
    .FRAC (FRAC_BITS)
  ) u_frame (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .vin       (ru_v),
    .degen_in  (ru_zero || ru_sb[3*W]),
    .fwd       (ru_fwd),
    .rgt       (ru_comp),
    .eye       (ru_eye),
    .vout      (fr_v),
    .degen_out (fr_degen),
    .rows      (fr_rows)
  );

  // Row serializer: holds one frame and sends its rows in order. It loads a
  // new frame in the cycle that the last row of the previous one is taken.
  logic signed [W-1:0] ser_rows [3][4];
  logic                ser_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_v <= 1'b0;
      cnt   <= ROW_RIGHT;
    end else if (ser_free) begin
      ser_v <= fr_v;
      cnt   <= ROW_RIGHT;
    end else if (!out_stall) begin
      cnt <= (cnt == ROW_RIGHT) ? ROW_UP : ROW_FWD;
    end
    if (ser_free && fr_v) begin
      ser_rows  <= fr_rows;
      ser_degen <= fr_degen;
    end
  end

  assign out_valid  = ser_v;
  assign row_index  = cnt;
  assign col0       = ser_rows[cnt][0];
  assign col1       = ser_rows[cnt][1];
  assign col2       = ser_rows[cnt][2];
  assign col3       = ser_rows[cnt][3];
  assign last_row   = (cnt == ROW_FWD);
  assign degenerate = ser_degen;

endmodule

[sim/lookat_view_matrix_tb.sv]
// Self-checking testbench for the lookat view-matrix generator.
// Depends on src/lvm_pkg.sv and src/lookat_view_matrix.sv (with its submodules).
`timescale 1ns / 1ps

module lookat_view_matrix_tb;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int ROW_RIGHT = 0;
  localparam int ROW_UP = 1;
  localparam int ROW_FWD = 2;
  localparam int DRAIN_CYCLES = 2 * FB + 200;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_REQUESTS = 460;
  localparam longint ONE = 64'sd65536;

  // One request: eye, target and up hint, index 0..2 is x..z.
  typedef struct {
    logic signed [CW-1:0] eye[3];
    logic signed [CW-1:0] tgt[3];
    logic signed [CW-1:0] up[3];
  } cam_req_t;

  // One matrix row as the block sends it.
  typedef struct {
    logic [1:0]    ridx;
    logic [CW-1:0] col[4];
    logic          last;
    logic          degen;
  } view_row_t;

  // Scoreboard: computes the three rows of each accepted request and checks
  // the rows that come out against them in order.
  class view_matrix_board;
    view_row_t rows_due[$];
    int errors;
    int requests;
    int degen_requests;
    int rows_seen;

    function longint unsigned isqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function longint unsigned mag(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // Scale so that the largest magnitude has exactly 31 bits.
    function bit scale(bit neg[3], longint unsigned m[3], output longint sc[3]);
      longint unsigned mx, s;
      int bl;
      mx = m[0];
      bl = 0;
      if (m[1] > mx) mx = m[1];
      if (m[2] > mx) mx = m[2];
      for (int i = 0; i < 3; i++) sc[i] = 0;
      if (mx == 0) return 0;
      while (bl < 64 && (mx >> bl) != 0) bl++;
      for (int i = 0; i < 3; i++) begin
        s = (bl > 31) ? (m[i] >> (bl - 31)) : (m[i] << (31 - bl));
        sc[i] = neg[i] ? -longint'(s) : longint'(s);
      end
      return 1;
    endfunction

    function bit unit(bit neg[3], longint unsigned m[3], output longint u[3]);
      longint sc[3];
      longint unsigned sum, len, a;
      sum = 0;
      for (int i = 0; i < 3; i++) u[i] = 0;
      if (!scale(neg, m, sc)) return 0;
      for (int i = 0; i < 3; i++) begin
        a = mag(sc[i]);
        sum += a * a;
      end
      len = isqrt(sum);
      for (int i = 0; i < 3; i++) begin
        a = ((mag(sc[i]) << FB) + (len >> 1)) / len;
        u[i] = neg[i] ? -longint'(a) : longint'(a);
      end
      return 1;
    endfunction

    function void cross3(longint a[3], longint b[3], output longint r[3]);
      r[0] = a[1] * b[2] - a[2] * b[1];
      r[1] = a[2] * b[0] - a[0] * b[2];
      r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function longint round_frac(longint v);
      longint unsigned m;
      m = (mag(v) + (64'd1 << (FB - 1))) >> FB;
      return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint clamped_product(longint a, longint b);
      longint unsigned ma, mb, p, lim;
      ma = mag(a);
      mb = mag(b);
      lim = 64'd1 << 61;
      if (ma != 0 && mb > lim / ma) p = lim;
      else p = ma * mb;
      if (p > lim) p = lim;
      return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    // Note an accepted request and queue its three expected rows.
    function void note_request(cam_req_t r);
      longint e[3], t[3], u[3], fwd[3], rgt[3], usc[3], rraw[3], upn[3];
      longint m4[3][4];
      longint acc;
      longint unsigned mg[3];
      bit ng[3];
      bit degen;
      view_row_t row;
      degen = 0;
      for (int i = 0; i < 3; i++) begin
        e[i] = longint'(r.eye[i]);
        t[i] = longint'(r.tgt[i]);
        u[i] = longint'(r.up[i]);
        ng[i] = e[i] < t[i];
        mg[i] = ng[i] ? longint'(t[i] - e[i]) : longint'(e[i] - t[i]);
      end
      if (!unit(ng, mg, fwd)) degen = 1;
      if (!degen) begin
        for (int i = 0; i < 3; i++) begin
          ng[i] = u[i] < 0;
          mg[i] = mag(u[i]);
        end
        if (!scale(ng, mg, usc)) begin
          degen = 1;
        end else begin
          cross3(usc, fwd, rraw);
          for (int i = 0; i < 3; i++) begin
            ng[i] = rraw[i] < 0;
            mg[i] = mag(rraw[i]);
          end
          if (!unit(ng, mg, rgt)) degen = 1;
        end
      end
      for (int k = 0; k < 3; k++)
        for (int i = 0; i < 4; i++) m4[k][i] = 0;
      if (!degen) begin
        cross3(fwd, rgt, upn);
        for (int i = 0; i < 3; i++) begin
          m4[ROW_RIGHT][i] = rgt[i];
          m4[ROW_UP][i] = round_frac(upn[i]);
          m4[ROW_FWD][i] = fwd[i];
        end
        for (int k = 0; k < 3; k++) begin
          acc = 0;
          for (int i = 0; i < 3; i++) acc += clamped_product(m4[k][i], e[i]);
          m4[k][3] = sat(-round_frac(acc));
          for (int i = 0; i < 3; i++) m4[k][i] = sat(m4[k][i]);
        end
      end
      requests++;
      if (degen) degen_requests++;
      for (int k = 0; k < 3; k++) begin
        row.ridx = k[1:0];
        for (int i = 0; i < 4; i++) row.col[i] = m4[k][i][CW-1:0];
        row.last = (k == ROW_FWD);
        row.degen = degen;
        rows_due.push_back(row);
      end
    endfunction

    function void check_row(view_row_t got);
      view_row_t want;
      rows_seen++;
      if (rows_due.size() == 0) begin
        $display("%0t: row with no request pending: row_index=%0d", $time, got.ridx);
        errors++;
        return;
      end
      want = rows_due.pop_front();
      if (got.ridx !== want.ridx) begin
        $display("%0t: row_index expected %0d, actual %0d", $time, want.ridx, got.ridx);
        errors++;
      end
      for (int i = 0; i < 4; i++)
        if (got.col[i] !== want.col[i]) begin
          $display("%0t: row %0d col%0d expected %h, actual %h",
                   $time, want.ridx, i, want.col[i], got.col[i]);
          errors++;
        end
      if (got.last !== want.last) begin
        $display("%0t: last_row expected %b, actual %b", $time, want.last, got.last);
        errors++;
      end
      if (got.degen !== want.degen) begin
        $display("%0t: degenerate expected %b, actual %b", $time, want.degen, got.degen);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] eye_x = '0, eye_y = '0, eye_z = '0;
  logic signed [CW-1:0] target_x = '0, target_y = '0, target_z = '0;
  logic signed [CW-1:0] up_x = '0, up_y = '0, up_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] row_index;
  logic signed [CW-1:0] col0, col1, col2, col3;
  logic last_row, degenerate;

  view_matrix_board board = new();
  int cycles = 0;
  bit hold_off_req = 0;
  bit stimulus_done = 0;

  lookat_view_matrix #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .eye_x(eye_x), .eye_y(eye_y), .eye_z(eye_z),
    .target_x(target_x), .target_y(target_y), .target_z(target_z),
    .up_x(up_x), .up_y(up_y), .up_z(up_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .row_index(row_index), .col0(col0), .col1(col1), .col2(col2), .col3(col3),
    .last_row(last_row), .degenerate(degenerate)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d rows still due", cycles, board.rows_due.size());
      $display("lookat_view_matrix: mismatch");
      $finish;
    end
  end

  // Both monitors sample at the clock edge, before any of this step's
  // nonblocking updates land, so they see exactly what the block saw.
  always @(posedge clk) begin
    cam_req_t r;
    if (!rst && in_valid && !in_stall) begin
      r.eye[0] = eye_x; r.eye[1] = eye_y; r.eye[2] = eye_z;
      r.tgt[0] = target_x; r.tgt[1] = target_y; r.tgt[2] = target_z;
      r.up[0] = up_x; r.up[1] = up_y; r.up[2] = up_z;
      board.note_request(r);
    end
  end

  always @(posedge clk) begin
    view_row_t got;
    if (!rst && out_valid && !out_stall) begin
      got.ridx = row_index;
      got.col[0] = col0; got.col[1] = col1; got.col[2] = col2; got.col[3] = col3;
      got.last = last_row;
      got.degen = degenerate;
      board.check_row(got);
    end
  end

  // Gap length: mostly zero or short, now and then long.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Receiver: the stall rate changes from window to window, including
  // windows with no stall at all. On request it holds off for a long
  // stretch so that the pipeline fills and pushes back on the sender.
  initial begin
    int pct;
    int left;
    int hold;
    pct = 0;
    left = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        for (hold = 0; hold < 600; hold++) @(posedge clk);
        hold_off_req = 0;
      end
      if (left == 0) begin
        case ($urandom_range(0, 3))
          0: pct = 0;
          1: pct = 20;
          2: pct = 50;
          default: pct = 85;
        endcase
        left = $urandom_range(20, 150);
      end
      left--;
      out_stall <= ($urandom_range(0, 99) < pct);
    end
  end

  // Present one request and hold it until the block takes it. in_valid
  // stays high across back-to-back requests without being lowered.
  task automatic send_request(cam_req_t r, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    eye_x <= r.eye[0]; eye_y <= r.eye[1]; eye_z <= r.eye[2];
    target_x <= r.tgt[0]; target_y <= r.tgt[1]; target_z <= r.tgt[2];
    up_x <= r.up[0]; up_y <= r.up[1]; up_z <= r.up[2];
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic cam_req_t make_req(longint ex, longint ey, longint ez,
                                        longint tx, longint ty, longint tz,
                                        longint ux, longint uy, longint uz);
    cam_req_t r;
    r.eye[0] = CW'(ex); r.eye[1] = CW'(ey); r.eye[2] = CW'(ez);
    r.tgt[0] = CW'(tx); r.tgt[1] = CW'(ty); r.tgt[2] = CW'(tz);
    r.up[0] = CW'(ux); r.up[1] = CW'(uy); r.up[2] = CW'(uz);
    return r;
  endfunction

  // A coordinate drawn from one of several ranges: full 32-bit, a typical
  // scene of a few hundred units, or a handful of LSBs.
  function automatic logic signed [CW-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $signed($urandom_range(0, 2048)) - 1024;
      2: return CW'((longint'($urandom_range(0, 2000)) - 1000) * ONE / 4);
      default: return CW'((longint'($urandom_range(0, 600)) - 300) * ONE
                          + longint'($urandom_range(0, 65535)));
    endcase
  endfunction

  function automatic cam_req_t random_req();
    cam_req_t r;
    longint k;
    for (int i = 0; i < 3; i++) begin
      r.eye[i] = pick_coord();
      r.tgt[i] = pick_coord();
      r.up[i] = pick_coord();
    end
    case ($urandom_range(0, 19))
      // Eye on top of the target.
      0: r.tgt = r.eye;
      // Up hint along the viewing line, sometimes reversed.
      1: begin
        k = $urandom_range(0, 1) ? 1 : -1;
        for (int i = 0; i < 3; i++) begin
          r.eye[i] = CW'((longint'($urandom_range(0, 200)) - 100) * ONE);
          r.tgt[i] = CW'((longint'($urandom_range(0, 200)) - 100) * ONE);
          r.up[i] = CW'(k * (longint'(r.eye[i]) - longint'(r.tgt[i])));
        end
      end
      2: r.up = '{0, 0, 0};
      // Conventional y-up camera.
      3, 4, 5, 6: r.up = '{0, CW'(longint'($urandom_range(1, 4)) * ONE), 0};
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    cam_req_t dir[$];
    int n;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests.
    dir.push_back(make_req(0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0));
    dir.push_back(make_req(3 * ONE, 4 * ONE, 5 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 0, ONE, 0));
    dir.push_back(make_req(ONE, 2 * ONE, 3 * ONE, 0, 0, 0, 0, 0, 0));
    dir.push_back(make_req(0, 0, 5 * ONE, 0, 0, 0, 0, 0, ONE));
    dir.push_back(make_req(0, 0, 5 * ONE, 0, 0, 0, 0, 0, -ONE));
    dir.push_back(make_req(2 * ONE, 2 * ONE, 2 * ONE, 0, 0, 0, 7, 7, 7));
    dir.push_back(make_req(2147483647, 2147483647, 2147483647,
                           -2147483648, -2147483648, -2147483648, 0, ONE, 0));
    dir.push_back(make_req(-2147483648, -2147483648, -2147483648,
                           2147483647, 2147483647, 2147483647, ONE, 0, 0));
    dir.push_back(make_req(2147483647, -2147483648, 2147483647, 0, 0, 0,
                           -2147483648, 2147483647, -2147483648));
    dir.push_back(make_req(1, 0, 0, 0, 0, 0, 0, 1, 0));
    dir.push_back(make_req(0, 1, 1, 0, 0, 0, 1, 0, 0));
    dir.push_back(make_req(2147483647, 2147483647, 2147483647,
                           2147483646, 2147483647, 2147483647, 0, 0, -1));
    dir.push_back(make_req(-2147483648, -2147483648, -2147483648,
                           -2147483648, -2147483648, -2147483647, 0, 2147483647, 0));
    dir.push_back(make_req(10 * ONE, -3 * ONE, ONE / 2, -ONE, 4 * ONE, 0, -1, 2147483647, 3));
    dir.push_back(make_req(-1, -1, -1, 0, 0, 0, 0, -1, 0));
    foreach (dir[i]) send_request(dir[i], (i % 3 == 0) ? 0 : 1);

    // Random requests, with one long receiver hold-off and one full drain.
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == 120) hold_off_req = 1;
      if (n == 300) begin
        in_valid <= 1'b0;
        while (board.rows_due.size() != 0) @(posedge clk);
      end
      send_request(random_req(), pick_gap());
    end
    in_valid <= 1'b0;
    stimulus_done = 1;

    while (board.rows_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests (%0d degenerate), %0d rows checked, %0d cycles",
             board.requests, board.degen_requests, board.rows_seen, cycles);
    if (board.errors == 0 && board.rows_due.size() == 0) begin
      $display("lookat_view_matrix: match");
    end else begin
      $display("%0d field errors, %0d rows never arrived", board.errors, board.rows_due.size());
      $display("lookat_view_matrix: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
src/lvm_pkg.sv
src/lvm_norm.sv
src/lvm_unit.sv
src/lvm_frame.sv
src/lookat_view_matrix.sv
sim/lookat_view_matrix_tb.sv
